@@ rtl/pda_pkg.sv @@
// shared widths, register indexes, reset values and control structs of the dwell alarm core
package pda_pkg;

    localparam int PDA_TRACK_COUNT = 256;
    localparam int PDA_COORD_BITS  = 12;

    localparam int ID_W    = 8;
    localparam int BOX_W   = 12;
    localparam int ELAP_W  = 16;
    localparam int FRAC_W  = 9;
    localparam int IMG_W   = 12;
    localparam int CNT_W   = 32;
    localparam int LVL_W   = 2;
    localparam int CIDX_W  = 3;
    localparam int IN_W    = 48;
    localparam int OUT_W   = 48;

    // register indexes
    localparam logic [CIDX_W-1:0] CFG_LINE_FRAC = 3'd0;
    localparam logic [CIDX_W-1:0] CFG_WATER_LVL = 3'd1;
    localparam logic [CIDX_W-1:0] CFG_IMG_H     = 3'd2;
    localparam logic [CIDX_W-1:0] CFG_MAX_CNT   = 3'd3;
    localparam logic [CIDX_W-1:0] CFG_RED_CNT   = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_YEL_CNT   = 3'd5;

    // register reset values
    localparam logic [FRAC_W-1:0] RST_LINE_FRAC = 9'd128;
    localparam logic [FRAC_W-1:0] RST_WATER_LVL = 9'd128;
    localparam logic [IMG_W-1:0]  RST_IMG_H     = 12'd480;
    localparam logic [CNT_W-1:0]  RST_MAX_CNT   = 32'd10000;
    localparam logic [CNT_W-1:0]  RST_RED_CNT   = 32'd6000;
    localparam logic [CNT_W-1:0]  RST_YEL_CNT   = 32'd3000;

    // alarm levels
    localparam logic [LVL_W-1:0] LVL_GREEN  = 2'd0;
    localparam logic [LVL_W-1:0] LVL_YELLOW = 2'd1;
    localparam logic [LVL_W-1:0] LVL_RED    = 2'd2;

    typedef struct packed {
        logic [FRAC_W-1:0] line_frac;
        logic [FRAC_W-1:0] water_lvl;
        logic [IMG_W-1:0]  img_h;
        logic [CNT_W-1:0]  max_cnt;
        logic [CNT_W-1:0]  red_cnt;
        logic [CNT_W-1:0]  yel_cnt;
    } t_pda_cfg;

    typedef struct packed {
        logic clear;    // write zero at sweep address, advance sweep
        logic accept;   // capture input beat
        logic mul;      // form products, latch stored count
        logic upd;      // compute new count, write table
        logic emit;     // load output register
    } t_pda_cmd;

    typedef struct packed {
        logic clr_last; // sweep at last entry
        logic out_busy; // output register holds an untaken result
    } t_pda_sts;

endpackage

@@ rtl/pda_ram.sv @@
// generic single write port, single read port ram with registered read
module pda_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/pda_ctrl.sv @@
// sequencing state machine: clearing sweep, then one item through four steps
module pda_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  pda_pkg::t_pda_sts i_sts,
    output pda_pkg::t_pda_cmd o_cmd
);
    import pda_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_MUL   = 3'd2;
    localparam logic [2:0] S_UPD   = 3'd3;
    localparam logic [2:0] S_LVL   = 3'd4;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready   = 1'b1;
                o_cmd.accept = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                o_cmd.upd = 1'b1;
                n_state   = S_LVL;
            end
            S_LVL: begin
                // wait here while the previous result is still untaken
                if (!i_sts.out_busy) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

@@ rtl/pda_dp.sv @@
// datapath: slot index, water line test, saturating count update, level and output register
module pda_dp #(
    parameter int TRACK_COUNT = pda_pkg::PDA_TRACK_COUNT,
    parameter int COORD_BITS  = pda_pkg::PDA_COORD_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  pda_pkg::t_pda_cfg           i_cfg,
    input  pda_pkg::t_pda_cmd           i_cmd,
    output pda_pkg::t_pda_sts           o_sts,
    input  logic [pda_pkg::IN_W-1:0]    i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [pda_pkg::OUT_W-1:0]   o_out_data
);
    import pda_pkg::*;

    localparam int IDX_W  = $clog2(TRACK_COUNT);
    localparam int MSK_B  = (COORD_BITS < BOX_W) ? COORD_BITS : BOX_W;
    localparam logic [BOX_W-1:0] COORD_MASK = BOX_W'((1 << MSK_B) - 1);
    localparam int PRD_W  = BOX_W + FRAC_W;

    // id modulo table depth by shifted compare and subtract
    function automatic logic [IDX_W-1:0] slot_of(logic [ID_W-1:0] id);
        logic [ID_W:0] r;
        r = {1'b0, id};
        for (int k = ID_W - 1; k >= 0; k--) begin
            if (32'(r) >= (TRACK_COUNT << k)) begin
                r = r - (ID_W + 1)'(TRACK_COUNT << k);
            end
        end
        return IDX_W'(r);
    endfunction

    logic [ID_W-1:0]   in_id;
    logic [BOX_W-1:0]  in_top;
    logic [BOX_W-1:0]  in_h;
    logic [ELAP_W-1:0] in_elap;
    logic [IDX_W-1:0]  in_slot;

    assign in_id   = i_in_data[7:0];
    assign in_top  = i_in_data[19:8] & COORD_MASK;
    assign in_h    = i_in_data[31:20] & COORD_MASK;
    assign in_elap = i_in_data[47:32];
    assign in_slot = slot_of(in_id);

    logic [ID_W-1:0]   r_id;
    logic [BOX_W-1:0]  r_top;
    logic [BOX_W-1:0]  r_h;
    logic [ELAP_W-1:0] r_elap;
    logic [IDX_W-1:0]  r_slot;
    logic [PRD_W-1:0]  r_base;
    logic [PRD_W-1:0]  r_hf;
    logic [PRD_W-1:0]  r_wi;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_new;
    logic [IDX_W-1:0]  r_clr_addr;
    logic              r_out_valid;
    logic [OUT_W-1:0]  r_out_data;

    // table
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [CNT_W-1:0]  ram_wdata;
    logic [CNT_W-1:0]  ram_rdata;
    logic [CNT_W-1:0]  n_new;

    assign ram_we    = i_cmd.clear | i_cmd.upd;
    assign ram_waddr = i_cmd.clear ? r_clr_addr : r_slot;
    assign ram_wdata = i_cmd.clear ? '0 : n_new;

    pda_ram #(
        .WIDTH (CNT_W),
        .DEPTH (TRACK_COUNT)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (in_slot),
        .o_rdata (ram_rdata)
    );

    // line test: (top+h)*256 >= h*frac + water*img
    logic             below;
    logic [CNT_W:0]   rise;
    logic [CNT_W-1:0] fall;
    logic [CNT_W:0]   pre;

    always_comb begin
        below = {1'b0, r_base} >= ((PRD_W + 1)'(r_hf) + (PRD_W + 1)'(r_wi));
        rise  = (CNT_W + 1)'(r_count) + (CNT_W + 1)'(r_elap);
        fall  = (r_count > CNT_W'(r_elap)) ? (r_count - CNT_W'(r_elap)) : '0;
        pre   = below ? rise : {1'b0, fall};
        n_new = (pre > (CNT_W + 1)'(i_cfg.max_cnt)) ? i_cfg.max_cnt : pre[CNT_W-1:0];
    end

    logic [LVL_W-1:0] lvl;

    always_comb begin
        if (r_new > i_cfg.red_cnt) begin
            lvl = LVL_RED;
        end else if (r_new > i_cfg.yel_cnt) begin
            lvl = LVL_YELLOW;
        end else begin
            lvl = LVL_GREEN;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_id   <= in_id;
            r_top  <= in_top;
            r_h    <= in_h;
            r_elap <= in_elap;
            r_slot <= in_slot;
        end
        if (i_cmd.mul) begin
            r_base  <= {(BOX_W + 1)'(r_top) + (BOX_W + 1)'(r_h), 8'b0};
            r_hf    <= PRD_W'(r_h) * PRD_W'(i_cfg.line_frac);
            r_wi    <= PRD_W'(i_cfg.water_lvl) * PRD_W'(i_cfg.img_h);
            r_count <= ram_rdata;
        end
        if (i_cmd.upd) begin
            r_new <= n_new;
        end
        if (i_cmd.emit) begin
            r_out_data <= {6'b0, lvl, r_new, r_id};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.clr_last = (r_clr_addr == IDX_W'(TRACK_COUNT - 1));
    assign o_sts.out_busy = r_out_valid & ~i_out_ready;
    assign o_out_valid    = r_out_valid;
    assign o_out_data     = r_out_data;

endmodule

@@ rtl/per_track_dwell_alarm_core.sv @@
// top level of the per-track dwell alarm: config registers, controller, datapath
//
//  channel   dir  handshake                       payload
//  s_axis    in   s_axis_tvalid / s_axis_tready   s_axis_tdata  48b, one tracked box
//  m_axis    out  m_axis_tvalid / m_axis_tready   m_axis_tdata  48b, one dwell result
//  cfg       in   i_cfg_valid / o_cfg_ready       i_cfg_index 3b, i_cfg_data 32b
//
//  each box goes through four steps: accept with table read, products, count update with
//  table write, level into output register; a new box waits until the last is emitted
//  after reset a sweep zeroes the count table, s_axis_tready low
//  config writes are taken in every cycle, also during the sweep
//  a result waiting on m_axis does not block the next accept; only the level step
//  waits while the output register is still full
module per_track_dwell_alarm_core #(
    parameter int TRACK_COUNT = pda_pkg::PDA_TRACK_COUNT,
    parameter int COORD_BITS  = pda_pkg::PDA_COORD_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input beat
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // track_id[7:0], box_top[19:8], box_height[31:20], elapsed_ms[47:32]
    input  logic [pda_pkg::IN_W-1:0]      s_axis_tdata,
    // result beat
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // out_track_id[7:0], dwell_ms[39:8], alarm_level[41:40], zero[47:42]
    output logic [pda_pkg::OUT_W-1:0]     m_axis_tdata,
    // config write
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pda_pkg::CIDX_W-1:0]    i_cfg_index,
    input  logic [pda_pkg::CNT_W-1:0]     i_cfg_data
);
    import pda_pkg::*;

    t_pda_cfg r_cfg;
    t_pda_cmd cmd;
    t_pda_sts sts;

    assign o_cfg_ready = 1'b1;

    // register file, unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.line_frac <= RST_LINE_FRAC;
            r_cfg.water_lvl <= RST_WATER_LVL;
            r_cfg.img_h     <= RST_IMG_H;
            r_cfg.max_cnt   <= RST_MAX_CNT;
            r_cfg.red_cnt   <= RST_RED_CNT;
            r_cfg.yel_cnt   <= RST_YEL_CNT;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_LINE_FRAC: r_cfg.line_frac <= i_cfg_data[FRAC_W-1:0];
                CFG_WATER_LVL: r_cfg.water_lvl <= i_cfg_data[FRAC_W-1:0];
                CFG_IMG_H:     r_cfg.img_h     <= i_cfg_data[IMG_W-1:0];
                CFG_MAX_CNT:   r_cfg.max_cnt   <= i_cfg_data;
                CFG_RED_CNT:   r_cfg.red_cnt   <= i_cfg_data;
                CFG_YEL_CNT:   r_cfg.yel_cnt   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // step sequencing
    pda_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // count table and arithmetic
    pda_dp #(
        .TRACK_COUNT (TRACK_COUNT),
        .COORD_BITS  (COORD_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (s_axis_tdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_data  (m_axis_tdata)
    );

endmodule
